// ===== sv/bdhr_pkg.sv =====
// Shared types, codes and defaults for the button debounce, hold and repeat unit.
package bdhr_pkg;

    // Default structure sizes.
    localparam int LANES_DEF        = 4;
    localparam int HISTORY_BITS_DEF = 5;

    // Lanes that have a pin, a mask bit and an output slot on the ports.
    localparam int PORT_LANES = 4;

    // Opcodes carried in the slave-side tuser.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_RESET  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W   = 2;
    localparam logic [1:0]  CFG_HOLD_TIME = 2'd0;
    localparam logic [1:0]  CFG_HOLD_TICK = 2'd1;

    // Configuration reset values.
    localparam logic [7:0] HOLD_TIME_RST = 8'd50;
    localparam logic [7:0] HOLD_TICK_RST = 8'd5;

    // Output beat layout.
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_HELD     = 2'd2
    } t_mode;

    // Per-lane command for one accepted beat.
    typedef struct packed {
        logic sample;
        logic lane_rst;
        logic clear;
        logic level;
    } t_lane_cmd;

    // Per-lane state after the beat has been applied.
    typedef struct packed {
        t_mode mode;
        logic  flag;
    } t_lane_status;

endpackage

// ===== sv/bdhr_lane.sv =====
// One button qualifier lane: sample history, press/hold state, hold count and repeat timer.
module bdhr_lane #(
    parameter int HISTORY_BITS = bdhr_pkg::HISTORY_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bdhr_pkg::t_lane_cmd    i_cmd,
    input  logic [7:0]             i_hold_time,
    input  logic [7:0]             i_hold_tick,
    output bdhr_pkg::t_lane_status o_next
);

    localparam logic [HISTORY_BITS-1:0] WIN_ONES = {HISTORY_BITS{1'b1}};

    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    bdhr_pkg::t_mode         r_mode, n_mode;
    logic [7:0]              r_cnt, n_cnt;
    logic [7:0]              r_timer, n_timer;
    logic                    r_flag, n_flag;
    logic [HISTORY_BITS-1:0] h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= WIN_ONES;
            r_mode  <= bdhr_pkg::MODE_RELEASED;
            r_cnt   <= '0;
            r_timer <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_hist  <= n_hist;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_timer <= n_timer;
            r_flag  <= n_flag;
        end
    end

    always_comb begin
        n_hist  = r_hist;
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_timer = r_timer;
        n_flag  = r_flag;
        h       = r_hist;
        if (i_cmd.lane_rst) begin
            n_hist  = WIN_ONES;
            n_mode  = bdhr_pkg::MODE_RELEASED;
            n_cnt   = '0;
            n_timer = '0;
            n_flag  = 1'b0;
        end else if (i_cmd.clear) begin
            n_flag = 1'b0;
        end else if (i_cmd.sample) begin
            case (r_mode)
                bdhr_pkg::MODE_RELEASED: begin
                    // A low sample can only clear the newest bit while released.
                    h[0] = h[0] & i_cmd.level;
                    if (h == '0) begin
                        n_hist = '0;
                        n_mode = bdhr_pkg::MODE_PRESSED;
                        n_flag = 1'b1;
                    end else begin
                        n_hist = {h[HISTORY_BITS-2:0], 1'b1};
                    end
                end
                bdhr_pkg::MODE_PRESSED, bdhr_pkg::MODE_HELD: begin
                    // A high sample can only set the newest bit while pressed.
                    h[0] = h[0] | i_cmd.level;
                    if (r_mode == bdhr_pkg::MODE_PRESSED && h == '0) begin
                        if (r_cnt >= i_hold_time) begin
                            n_mode = bdhr_pkg::MODE_HELD;
                        end
                        n_cnt = r_cnt + 8'd1;
                    end
                    if (h == WIN_ONES) begin
                        n_hist = WIN_ONES;
                        n_mode = bdhr_pkg::MODE_RELEASED;
                        n_cnt  = '0;
                    end else begin
                        n_hist = {h[HISTORY_BITS-2:0], 1'b0};
                        // The repeat step also runs on the tick that enters held.
                        if (n_mode == bdhr_pkg::MODE_HELD) begin
                            if (r_timer == i_hold_tick) begin
                                n_flag  = 1'b1;
                                n_timer = '0;
                            end else begin
                                n_timer = r_timer + 8'd1;
                            end
                        end
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    assign o_next.mode = n_mode;
    assign o_next.flag = n_flag;

endmodule

// ===== sv/bdhr_merge.sv =====
// Merging stage: packs the lane states into one result beat behind an output register and skid.
module bdhr_merge #(
    parameter int LANES = bdhr_pkg::LANES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  bdhr_pkg::t_lane_status        i_status [LANES],
    input  logic                          i_take_ready,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [bdhr_pkg::OUT_DATA_W-1:0] o_data
);

    logic [bdhr_pkg::OUT_DATA_W-1:0] w_packed;
    logic [bdhr_pkg::OUT_DATA_W-1:0] r_out_data, r_skid_data;
    logic                            r_out_valid, r_skid_valid;
    logic                            w_take;

    // Slot layout: lane i state at [2i+1:2i], lane i flag at bit 8+i.
    genvar g;
    generate
        for (g = 0; g < bdhr_pkg::PORT_LANES; g++) begin : g_slot
            if (g < LANES) begin : g_live
                assign w_packed[2*g +: 2] = i_status[g].mode;
                assign w_packed[2*bdhr_pkg::PORT_LANES + g] = i_status[g].flag;
            end else begin : g_absent
                assign w_packed[2*g +: 2] = 2'b00;
                assign w_packed[2*bdhr_pkg::PORT_LANES + g] = 1'b0;
            end
        end
    endgenerate
    assign w_packed[bdhr_pkg::OUT_DATA_W-1:3*bdhr_pkg::PORT_LANES] = '0;

    assign w_take  = r_out_valid & i_take_ready;
    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_load;
            end else begin
                r_out_valid  <= i_load;
            end
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                if (i_load) begin
                    r_skid_data <= w_packed;
                end
            end else if (i_load) begin
                r_out_data <= w_packed;
            end
        end else if (i_load) begin
            r_skid_data <= w_packed;
        end
    end

endmodule

// ===== sv/button_debounce_hold_repeat_unit.sv =====
// Top level of the four-lane button debounce, hold and auto-repeat unit.
//
// This block qualifies active-low push buttons, one lane per button, and
// takes one beat per clock cycle, while its skid is empty, on its slave
// stream. A result is registered as its beat is accepted; if the consumer
// holds off, the result waits in the output stage and later beats queue
// behind it. Every lane updates its state (a history shift, an 8-bit
// compare and an 8-bit increment), and a two-deep output stage (output
// register plus skid) lets a new beat enter while the previous result
// still waits for the consumer. Each slave beat
// carries an opcode in tuser: a sample tick shifts every lane's pin level
// into its history and runs the press, hold, release and repeat rules; a
// lane reset returns the lanes selected by lane_mask to their power-up
// state; a flag clear drops the sticky event flags of the selected lanes;
// the fourth code changes nothing. Each slave beat yields exactly one master
// beat with every lane's state and event flag as they stand after the
// update. The hold_time and hold_tick registers are written through the
// configuration channel, which is always ready; write them only while no
// beat is in flight. Writes to an index past the second register are
// dropped.
module button_debounce_hold_repeat_unit #(
    parameter int LANES        = bdhr_pkg::LANES_DEF,
    parameter int HISTORY_BITS = bdhr_pkg::HISTORY_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata from bit 0 up: pin_levels[3:0], lane_mask[7:4].
    input  logic [7:0]                       s_axis_tdata,
    // tuser from bit 0 up: opcode[1:0].
    input  logic [1:0]                       s_axis_tuser,
    // Master stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata from bit 0 up: lane0_state[1:0], lane1_state[3:2],
    // lane2_state[5:4], lane3_state[7:6], event_flags[11:8], zero[15:12].
    output logic [bdhr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bdhr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    logic [7:0] r_hold_time;
    logic [7:0] r_hold_tick;
    logic       w_accept;
    logic [1:0] w_opcode;
    logic [3:0] w_pins;
    logic [3:0] w_mask;

    bdhr_pkg::t_lane_status w_status [LANES];

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time <= bdhr_pkg::HOLD_TIME_RST;
            r_hold_tick <= bdhr_pkg::HOLD_TICK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bdhr_pkg::CFG_HOLD_TIME: r_hold_time <= i_cfg_data;
                bdhr_pkg::CFG_HOLD_TICK: r_hold_tick <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_accept = s_axis_tvalid & s_axis_tready;
    assign w_opcode = s_axis_tuser;
    assign w_pins   = s_axis_tdata[3:0];
    assign w_mask   = s_axis_tdata[7:4];

    // One qualifier per lane. Lanes past the port width see a low pin and a
    // clear mask bit, so they only ever respond to sample ticks.
    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            bdhr_pkg::t_lane_cmd w_cmd;
            logic                w_level;
            logic                w_sel;

            if (g < bdhr_pkg::PORT_LANES) begin : g_pin
                assign w_level = w_pins[g];
                assign w_sel   = w_mask[g];
            end else begin : g_nopin
                assign w_level = 1'b0;
                assign w_sel   = 1'b0;
            end

            assign w_cmd.sample   = w_accept && (w_opcode == bdhr_pkg::OP_SAMPLE);
            assign w_cmd.lane_rst = w_accept && (w_opcode == bdhr_pkg::OP_RESET) && w_sel;
            assign w_cmd.clear    = w_accept && (w_opcode == bdhr_pkg::OP_CLEAR) && w_sel;
            assign w_cmd.level    = w_level;

            bdhr_lane #(
                .HISTORY_BITS (HISTORY_BITS)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_hold_time (r_hold_time),
                .i_hold_tick (r_hold_tick),
                .o_next      (w_status[g])
            );
        end
    endgenerate

    // The merge stage captures the post-update lane states on the same edge
    // that the lanes commit them.
    bdhr_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_status     (w_status),
        .i_take_ready (m_axis_tready),
        .o_ready      (s_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_data       (m_axis_tdata)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the button debounce, hold and repeat unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdhr_pkg::*;

    localparam int HB              = HISTORY_BITS_DEF;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 4;

    // Register indexes past the two real registers; writes there are dropped.
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    // One row of the directed plan is either a stream beat or a register write.
    typedef enum logic {
        ROW_BEAT  = 1'b0,
        ROW_WRITE = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  op;
        logic [3:0]  pins;
        logic [3:0]  mask;
        logic [1:0]  reg_idx;
        logic [7:0]  reg_val;
        logic        typed;
        logic [15:0] want;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [7:0]  i_cfg_data;

    // Shadow copy of the lanes, kept in step with every accepted beat.
    logic [HB-1:0]         lane_hist      [PORT_LANES];
    t_mode                 lane_mode      [PORT_LANES];
    logic [7:0]            lane_hold_cnt  [PORT_LANES];
    logic [7:0]            lane_rep_timer [PORT_LANES];
    logic [PORT_LANES-1:0] lane_flag;
    logic [7:0]            hold_time_r;
    logic [7:0]            hold_tick_r;

    // Status words still owed by the block, oldest first.
    logic [15:0] pending_status [$];
    t_plan_row   plan [$];

    // A directed row may carry a status word typed in by hand; the monitor
    // picks it up together with the beat it belongs to.
    logic        beat_typed;
    logic [15:0] beat_want;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_off_left;
    int mismatch_count;
    int status_seen;
    int unsigned cycle_count;

    button_debounce_hold_repeat_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Return one lane to its power-up state.
    function automatic void drop_lane(int i);
        lane_hist[i]      = '1;
        lane_mode[i]      = MODE_RELEASED;
        lane_hold_cnt[i]  = 8'd0;
        lane_rep_timer[i] = 8'd0;
        lane_flag[i]      = 1'b0;
    endfunction

    // Apply one beat to the shadow lanes and return the status word that the
    // block should send for it.
    function automatic logic [15:0] apply_beat(logic [1:0] op, logic [3:0] pins,
                                               logic [3:0] mask);
        logic [HB-1:0] h;
        logic [15:0]   word;
        int            i;
        word = '0;
        for (i = 0; i < PORT_LANES; i++) begin
            case (op)
                OP_SAMPLE: begin
                    h = lane_hist[i];
                    if (lane_mode[i] == MODE_RELEASED) begin
                        // A low pin only lands in bit 0 for the window test;
                        // the shift then refills bit 0 with a one.
                        if (!pins[i])
                            h[0] = 1'b0;
                        if (h == '0) begin
                            lane_hist[i] = '0;
                            lane_mode[i] = MODE_PRESSED;
                            lane_flag[i] = 1'b1;
                        end else begin
                            lane_hist[i] = {h[HB-2:0], 1'b1};
                        end
                    end else begin
                        h[0] = h[0] | pins[i];
                        if (lane_mode[i] == MODE_PRESSED && h == '0) begin
                            if (lane_hold_cnt[i] >= hold_time_r)
                                lane_mode[i] = MODE_HELD;
                            lane_hold_cnt[i] = lane_hold_cnt[i] + 8'd1;
                        end
                        if (&h) begin
                            // Release keeps the repeat timer as it is.
                            lane_hist[i]     = '1;
                            lane_mode[i]     = MODE_RELEASED;
                            lane_hold_cnt[i] = 8'd0;
                        end else begin
                            lane_hist[i] = {h[HB-2:0], 1'b0};
                            if (lane_mode[i] == MODE_HELD) begin
                                if (lane_rep_timer[i] == hold_tick_r) begin
                                    lane_flag[i]      = 1'b1;
                                    lane_rep_timer[i] = 8'd0;
                                end else begin
                                    lane_rep_timer[i] = lane_rep_timer[i] + 8'd1;
                                end
                            end
                        end
                    end
                end
                OP_RESET: begin
                    if (mask[i])
                        drop_lane(i);
                end
                OP_CLEAR: begin
                    if (mask[i])
                        lane_flag[i] = 1'b0;
                end
                default: ;
            endcase
            word[2*i +: 2] = lane_mode[i];
            word[8 + i]    = lane_flag[i];
        end
        return word;
    endfunction

    // One line per mismatching field.
    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH status %0d %s: got %0h, expected %0h",
                 status_seen, field, got, want);
        mismatch_count++;
    endtask

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("button_debounce_hold_repeat_unit verification failed");
            $finish;
        end
    end

    // Consumer side: random back-pressure, plus a long hold-off on request so
    // that the output stage fills and the block stalls its input.
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: every accepted input beat queues its expected status word, and
    // every accepted output beat is checked against the oldest one.
    always @(posedge i_clk) begin : monitor
        logic [15:0] want;
        logic [15:0] got;
        int          i;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_beat(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4]);
                pending_status.push_back(beat_typed ? beat_want : want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_status.size() == 0) begin
                    report_mismatch("unexpected beat", got, '0);
                end else begin
                    want = pending_status.pop_front();
                    for (i = 0; i < PORT_LANES; i++)
                        if (got[2*i +: 2] !== want[2*i +: 2])
                            report_mismatch($sformatf("lane%0d_state", i), got, want);
                    if (got[11:8] !== want[11:8])
                        report_mismatch("event_flags", got, want);
                    if (got[15:12] !== 4'd0)
                        report_mismatch("padding", got, want);
                end
                status_seen++;
            end
        end
    end

    // Offer one beat, with random gaps in front of it, and return at the
    // rising edge where it is taken. Valid stays high until the next call.
    task automatic send_beat(logic [1:0] op, logic [3:0] pins, logic [3:0] mask,
                             logic typed, logic [15:0] want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mask, pins};
        s_axis_tuser  <= op;
        beat_typed    <= typed;
        beat_want     <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering beats and wait until the block has answered all of them.
    task automatic drain_stream();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
    endtask

    // Registers change only with nothing in flight.
    task automatic write_register(logic [1:0] idx, logic [7:0] val);
        drain_stream();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HOLD_TIME: hold_time_r = val;
            CFG_HOLD_TICK: hold_tick_r = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_beat(logic [1:0] op, logic [3:0] pins, logic [3:0] mask,
                                     logic typed, logic [15:0] want);
        t_plan_row r;
        r       = '0;
        r.kind  = ROW_BEAT;
        r.op    = op;
        r.pins  = pins;
        r.mask  = mask;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic void add_write(logic [1:0] idx, logic [7:0] val);
        t_plan_row r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        plan.push_back(r);
    endfunction

    // Random traffic shaped like real button use: each lane follows a plan of
    // clean presses and releases of random length, with occasional bounce.
    // Lanes in long_lanes get very long presses and no bounce so that they
    // reach the hold state even at the largest hold_time. A hold-off of the
    // consumer starts at item stall_at, and the producer waits for all
    // answers at item drain_at.
    task automatic run_traffic(int count, logic [3:0] long_lanes, int stall_at,
                               int drain_at);
        int         n;
        int         i;
        int         pick;
        int         left [PORT_LANES];
        logic [1:0] op;
        logic [3:0] pins;
        logic [3:0] mask;
        logic [3:0] level;
        level = 4'hF;
        for (i = 0; i < PORT_LANES; i++)
            left[i] = 0;
        for (n = 0; n < count; n++) begin
            if (n == stall_at)
                hold_off_left = HOLD_OFF_CYCLES;
            if (n == drain_at)
                drain_stream();
            pick = $urandom_range(0, 99);
            pins = 4'($urandom_range(0, 15));
            mask = 4'($urandom_range(0, 15));
            if (pick < 86) begin
                op = OP_SAMPLE;
                for (i = 0; i < PORT_LANES; i++) begin
                    if (left[i] == 0) begin
                        level[i] = ~level[i];
                        if (long_lanes[i])
                            left[i] = level[i] ? $urandom_range(6, 12)
                                               : $urandom_range(270, 320);
                        else if ($urandom_range(0, 9) < 7)
                            left[i] = $urandom_range(1, 8);
                        else
                            left[i] = $urandom_range(10, 40);
                    end
                    left[i]--;
                    if (long_lanes[i])
                        pins[i] = level[i];
                    else
                        pins[i] = level[i] ^ ($urandom_range(0, 99) < 8);
                end
            end else if (pick < 92) begin
                op = OP_CLEAR;
            end else if (pick < 96) begin
                op   = OP_RESET;
                mask = mask & ~long_lanes;
            end else begin
                op = OP_NOP;
            end
            send_beat(op, pins, mask, 1'b0, '0);
        end
    endtask

    initial begin
        int k;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_NOP;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_HOLD_TIME;
        i_cfg_data     = '0;
        beat_typed     = 1'b0;
        beat_want      = '0;
        tx_idle_pct    = 32;
        rx_idle_pct    = 32;
        hold_off_left  = 0;
        mismatch_count = 0;
        status_seen    = 0;
        cycle_count    = 0;
        hold_time_r    = HOLD_TIME_RST;
        hold_tick_r    = HOLD_TICK_RST;
        for (k = 0; k < PORT_LANES; k++)
            drop_lane(k);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan. Under the reset values: an idle tick, four low ticks
        // that only fill the window, the fifth that presses every lane, then a
        // flag clear, a lane reset and the unused opcode.
        add_beat(OP_SAMPLE, 4'hF, 4'h0, 1'b1, 16'h0000);
        for (k = 0; k < 4; k++)
            add_beat(OP_SAMPLE, 4'h0, 4'hF, 1'b1, 16'h0000);
        add_beat(OP_SAMPLE, 4'h0, 4'hF, 1'b1, 16'h0F55);
        add_beat(OP_CLEAR,  4'hF, 4'h5, 1'b1, 16'h0A55);
        add_beat(OP_RESET,  4'hF, 4'h3, 1'b1, 16'h0850);
        add_beat(OP_NOP,    4'hF, 4'hF, 1'b1, 16'h0850);
        // Bounce on pressed and released lanes.
        add_beat(OP_SAMPLE, 4'hF, 4'h0, 1'b0, '0);
        add_beat(OP_SAMPLE, 4'h5, 4'hA, 1'b0, '0);
        // Smallest hold_time: the first all-low window after a press enters
        // the hold, and the repeat step runs on that same tick. Writes to the
        // spare indexes must change nothing.
        add_write(CFG_HOLD_TIME, 8'd0);
        add_write(CFG_HOLD_TICK, 8'd1);
        add_write(CFG_SPARE_LO, 8'hFF);
        add_write(CFG_SPARE_HI, 8'h00);
        for (k = 0; k < 7; k++)
            add_beat(OP_SAMPLE, 4'h0, 4'h0, 1'b0, '0);
        add_beat(OP_CLEAR, 4'h0, 4'hF, 1'b0, '0);
        add_beat(OP_SAMPLE, 4'h0, 4'h0, 1'b0, '0);
        // Five high ticks release held lanes; the repeat timer is kept.
        for (k = 0; k < 5; k++)
            add_beat(OP_SAMPLE, 4'hF, 4'hF, 1'b0, '0);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE)
                write_register(plan[k].reg_idx, plan[k].reg_val);
            else
                send_beat(plan[k].op, plan[k].pins, plan[k].mask, plan[k].typed,
                          plan[k].want);
        end

        // Short hold and back-to-back repeats.
        write_register(CFG_HOLD_TIME, 8'd2);
        write_register(CFG_HOLD_TICK, 8'd0);
        run_traffic(150, 4'b0000, -1, -1);

        // Large settings; lane 0 is held down long enough to reach the hold.
        write_register(CFG_HOLD_TIME, 8'd254);
        write_register(CFG_HOLD_TICK, 8'd255);
        run_traffic(380, 4'b0001, -1, -1);

        // A stretch at full rate on both sides. A repeat timer left large by
        // the previous phase must count on past the new, smaller hold_tick.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_register(CFG_HOLD_TIME, 8'd5);
        write_register(CFG_HOLD_TICK, 8'd3);
        run_traffic(150, 4'b0000, -1, -1);

        // Random gaps again, with a long consumer hold-off and later a full
        // drain by the producer.
        tx_idle_pct = 32;
        rx_idle_pct = 32;
        write_register(CFG_HOLD_TIME, 8'd1);
        write_register(CFG_HOLD_TICK, 8'd7);
        run_traffic(180, 4'b0000, 60, 120);

        drain_stream();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("button_debounce_hold_repeat_unit verification clean");
        else
            $display("button_debounce_hold_repeat_unit verification failed");
        $finish;
    end

endmodule
